@@ src/raft_leader_election_defines.svh @@
// Assertion macros for the raft leader election block
`ifndef RAFT_LEADER_ELECTION_DEFINES_SVH
`define RAFT_LEADER_ELECTION_DEFINES_SVH

`ifndef SYNTHESIS
`define RLE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("raft_leader_election: assertion failed");
`define RLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("raft_leader_election: assertion failed");
`else
`define RLE_ASSERT(lbl, clk, rstn, prop)
`define RLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ src/rle_pkg.sv @@
// Shared types and constants for the raft leader election block
package rle_pkg;

    localparam int MAX_NODES_DEF = 16;

    localparam int TERM_W  = 31;
    localparam int ID_W    = 4;
    localparam int IDX_W   = 32;
    localparam int VOTE_W  = 5;
    localparam int SIZE_W  = 5;
    localparam int CMD_W   = 2;
    localparam int ROLE_W  = 2;
    localparam int SEND_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};
    localparam logic [VOTE_W-1:0] VOTE_MAX = {VOTE_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_VOTE_REQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VOTE_REPLY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT    = 2'd2;

    localparam logic [ROLE_W-1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_LEADER    = 2'd2;

    localparam logic [SEND_W-1:0] SEND_NONE      = 2'd0;
    localparam logic [SEND_W-1:0] SEND_REPLY     = 2'd1;
    localparam logic [SEND_W-1:0] SEND_BROADCAST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SIZE = 2'd1;

    // classified event as held in the queue
    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [ID_W-1:0]       from_id;
        logic [TERM_W-1:0]     msg_term;
        logic                  cand_match;
        logic                  log_ok;
        logic                  is_ack;
        logic signed [IDX_W-1:0] local_last_log_index;
        logic [TERM_W-1:0]     local_last_log_term;
    } item_t;

endpackage

@@ src/rle_front.sv @@
// Input stage: accepts events and classifies vote requests
module rle_front
    import rle_pkg::*;
(
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CMD_W-1:0]        s_cmd,
    input  logic [ID_W-1:0]         s_from_id,
    input  logic [TERM_W-1:0]       s_msg_term,
    input  logic [ID_W-1:0]         s_cand_id,
    input  logic signed [IDX_W-1:0] s_req_last_log_index,
    input  logic [TERM_W-1:0]       s_req_last_log_term,
    input  logic                    s_is_ack,
    input  logic signed [IDX_W-1:0] s_local_last_log_index,
    input  logic [TERM_W-1:0]       s_local_last_log_term,
    input  logic                    q_full,
    output logic                    push,
    output item_t                   item
);

    logic log_ok;

    // candidate log at least as up to date as ours
    assign log_ok = (s_req_last_log_term > s_local_last_log_term) ||
                    ((s_req_last_log_term == s_local_last_log_term) &&
                     (s_req_last_log_index >= s_local_last_log_index));

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        item.cmd                  = s_cmd;
        item.from_id              = s_from_id;
        item.msg_term             = s_msg_term;
        item.cand_match           = (s_cand_id == s_from_id);
        item.log_ok               = log_ok;
        item.is_ack               = s_is_ack;
        item.local_last_log_index = s_local_last_log_index;
        item.local_last_log_term  = s_local_last_log_term;
    end

endmodule

@@ src/rle_queue.sv @@
// Short queue between the front and back stages
module rle_queue
    import rle_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t head
);

    item_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/rle_back.sv @@
// Election state, configuration registers and result register
`include "raft_leader_election_defines.svh"

module rle_back
    import rle_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     q_empty,
    input  item_t                    head,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SEND_W-1:0]        m_send_kind,
    output logic                     m_vote_granted,
    output logic [ID_W-1:0]          m_dest_id,
    output logic [TERM_W-1:0]        m_out_term,
    output logic signed [IDX_W-1:0]  m_out_last_log_index,
    output logic [TERM_W-1:0]        m_out_last_log_term,
    output logic [ROLE_W-1:0]        m_role,
    output logic                     m_became_follower,
    output logic                     m_became_candidate,
    output logic                     m_became_leader,
    output logic                     m_reset_election_timer
);

    logic [ID_W-1:0]       own_id_reg;
    logic [SIZE_W-1:0]     size_reg;

    logic [TERM_W-1:0]     term_reg, term_next;
    logic [ROLE_W-1:0]     role_reg, role_next;
    logic                  voted_reg, voted_next;
    logic [ID_W-1:0]       vnode_reg, vnode_next;
    logic [VOTE_W-1:0]     count_reg, count_next;
    logic [MAX_NODES-1:0]  mask_reg, mask_next;

    logic                  m_valid_reg, m_valid_next;
    logic [SEND_W-1:0]     m_send_kind_reg;
    logic                  m_vote_granted_reg;
    logic [ID_W-1:0]       m_dest_id_reg;
    logic [TERM_W-1:0]     m_out_term_reg;
    logic signed [IDX_W-1:0] m_out_last_log_index_reg;
    logic [TERM_W-1:0]     m_out_last_log_term_reg;
    logic [ROLE_W-1:0]     m_role_reg;
    logic                  m_became_follower_reg;
    logic                  m_became_candidate_reg;
    logic                  m_became_leader_reg;
    logic                  m_reset_timer_reg;

    logic                  term_gt, term_lt, from_ok, grant;
    logic [MAX_NODES-1:0]  from_bit;
    logic [VOTE_W-1:0]     half;
    logic [SEND_W-1:0]     r_send;
    logic                  r_granted, r_bf, r_bc, r_bl, r_timer;
    logic [ID_W-1:0]       r_dest;
    logic signed [IDX_W-1:0] r_idx;
    logic [TERM_W-1:0]     r_lterm;

    assign pop     = !q_empty && (!m_valid_reg || m_ready);
    assign term_gt = head.msg_term > term_reg;
    assign term_lt = head.msg_term < term_reg;
    assign from_ok = (32'(head.from_id) < 32'(MAX_NODES));
    assign from_bit = MAX_NODES'(1) << head.from_id;
    assign half    = VOTE_W'(size_reg >> 1);

    always_comb begin
        term_next  = term_reg;
        role_next  = role_reg;
        voted_next = voted_reg;
        vnode_next = vnode_reg;
        count_next = count_reg;
        mask_next  = mask_reg;
        grant      = 1'b0;
        r_send     = SEND_NONE;
        r_granted  = 1'b0;
        r_dest     = '0;
        r_idx      = '0;
        r_lterm    = '0;
        r_bf       = 1'b0;
        r_bc       = 1'b0;
        r_bl       = 1'b0;
        r_timer    = 1'b0;
        if (pop) begin
            case (head.cmd)
                CMD_VOTE_REQ: begin
                    if (term_gt) begin
                        term_next  = head.msg_term;
                        role_next  = ROLE_FOLLOWER;
                        voted_next = 1'b0;
                        vnode_next = '0;
                        count_next = '0;
                        mask_next  = '0;
                        r_bf       = 1'b1;
                        r_timer    = 1'b1;
                    end
                    grant = head.cand_match && !term_lt && head.log_ok &&
                            (!voted_next || (vnode_next == head.from_id));
                    if (grant) begin
                        r_timer    = 1'b1;
                        voted_next = 1'b1;
                        vnode_next = head.from_id;
                    end
                    r_send    = SEND_REPLY;
                    r_granted = grant;
                    r_dest    = head.from_id;
                end
                CMD_VOTE_REPLY: begin
                    if (role_reg == ROLE_CANDIDATE) begin
                        if (term_gt) begin
                            term_next  = head.msg_term;
                            role_next  = ROLE_FOLLOWER;
                            voted_next = 1'b0;
                            vnode_next = '0;
                            count_next = '0;
                            mask_next  = '0;
                            r_bf       = 1'b1;
                            r_timer    = 1'b1;
                        end else if (!term_lt) begin
                            if (head.is_ack && from_ok && ((mask_reg & from_bit) == '0)) begin
                                mask_next = mask_reg | from_bit;
                                if (count_reg != VOTE_MAX) begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            if (count_next > half) begin
                                role_next = ROLE_LEADER;
                                r_bl      = 1'b1;
                            end
                        end
                    end
                end
                CMD_TIMEOUT: begin
                    role_next  = ROLE_CANDIDATE;
                    term_next  = (term_reg == TERM_MAX) ? term_reg : term_reg + 1'b1;
                    voted_next = 1'b1;
                    vnode_next = own_id_reg;
                    count_next = VOTE_W'(1);
                    mask_next  = '0;
                    r_bc       = 1'b1;
                    r_send     = SEND_BROADCAST;
                    r_idx      = head.local_last_log_index;
                    r_lterm    = head.local_last_log_term;
                    if (half == '0) begin
                        role_next = ROLE_LEADER;
                        r_bl      = 1'b1;
                    end else begin
                        r_timer   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid_next = pop || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg  <= '0;
            size_reg    <= SIZE_W'(1);
            term_reg    <= '0;
            role_reg    <= ROLE_FOLLOWER;
            voted_reg   <= 1'b0;
            vnode_reg   <= '0;
            count_reg   <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_OWN_NODE_ID:  own_id_reg <= cfg_data[ID_W-1:0];
                    CFG_CLUSTER_SIZE: size_reg   <= cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
            term_reg    <= term_next;
            role_reg    <= role_next;
            voted_reg   <= voted_next;
            vnode_reg   <= vnode_next;
            count_reg   <= count_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_send_kind_reg          <= r_send;
            m_vote_granted_reg       <= r_granted;
            m_dest_id_reg            <= r_dest;
            m_out_term_reg           <= term_next;
            m_out_last_log_index_reg <= r_idx;
            m_out_last_log_term_reg  <= r_lterm;
            m_role_reg               <= role_next;
            m_became_follower_reg    <= r_bf;
            m_became_candidate_reg   <= r_bc;
            m_became_leader_reg      <= r_bl;
            m_reset_timer_reg        <= r_timer;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_send_kind            = m_send_kind_reg;
    assign m_vote_granted         = m_vote_granted_reg;
    assign m_dest_id              = m_dest_id_reg;
    assign m_out_term             = m_out_term_reg;
    assign m_out_last_log_index   = m_out_last_log_index_reg;
    assign m_out_last_log_term    = m_out_last_log_term_reg;
    assign m_role                 = m_role_reg;
    assign m_became_follower      = m_became_follower_reg;
    assign m_became_candidate     = m_became_candidate_reg;
    assign m_became_leader        = m_became_leader_reg;
    assign m_reset_election_timer = m_reset_timer_reg;

    // term only moves forward
    `RLE_ASSERT_NEXT(a_term_mono, aclk, aresetn, 1'b1, term_reg >= $past(term_reg))
    `RLE_ASSERT(a_leader_has_votes, aclk, aresetn, (role_reg == ROLE_LEADER) |-> (count_reg != '0))
    // own vote plus one per distinct granting peer
    `RLE_ASSERT(a_count_mask, aclk, aresetn, ((count_reg == '0) && (mask_reg == '0)) || (count_reg == VOTE_MAX) || (32'(count_reg) == 32'($countones(mask_reg)) + 32'd1))
    `RLE_ASSERT_NEXT(a_timeout_role, aclk, aresetn, pop && (head.cmd == CMD_TIMEOUT), role_reg != ROLE_FOLLOWER)
    `RLE_ASSERT(a_leader_flag, aclk, aresetn, (m_valid_reg && m_became_leader_reg) |-> (m_role_reg == ROLE_LEADER))

endmodule

@@ src/raft_leader_election.sv @@
// Top level of the raft leader election engine
//
// One node's election engine. Events arrive on the s_ channel (valid/ready):
// a vote request, a vote reply or an election timeout. Each accepted event
// gives exactly one result transfer on the m_ channel (valid/ready), in order.
// The cfg_ channel writes own_node_id (index 0) and cluster_size (index 1);
// writes are taken at once. The user must see that writes are made only
// while the block is idle; the block itself does not enforce this. An
// accepted event is written into the queue before the back takes it from
// the queue head. Throughput: one event per cycle while the receiver does
// not stall; the front classifies the event and pushes it into a two-entry
// queue, the back updates the election state and result register together.
// When the receiver stalls the result register holds, the back stops taking
// from the queue, and s_ready drops once the queue is full.
// Reset (aresetn low, synchronous) returns the node to follower in term 0
// with no vote, empties the queue and the result register, and sets
// own_node_id to 0 and cluster_size to 1.
module raft_leader_election
    import rle_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic [ID_W-1:0]          s_from_id,
    input  logic [TERM_W-1:0]        s_msg_term,
    input  logic [ID_W-1:0]          s_cand_id,
    input  logic signed [IDX_W-1:0]  s_req_last_log_index,
    input  logic [TERM_W-1:0]        s_req_last_log_term,
    input  logic                     s_is_ack,
    input  logic signed [IDX_W-1:0]  s_local_last_log_index,
    input  logic [TERM_W-1:0]        s_local_last_log_term,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SEND_W-1:0]        m_send_kind,
    output logic                     m_vote_granted,
    output logic [ID_W-1:0]          m_dest_id,
    output logic [TERM_W-1:0]        m_out_term,
    output logic signed [IDX_W-1:0]  m_out_last_log_index,
    output logic [TERM_W-1:0]        m_out_last_log_term,
    output logic [ROLE_W-1:0]        m_role,
    output logic                     m_became_follower,
    output logic                     m_became_candidate,
    output logic                     m_became_leader,
    output logic                     m_reset_election_timer
);

    logic  q_full, q_empty, push, pop;
    item_t push_item, head;

    assign cfg_ready = 1'b1;

    rle_front u_front (
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_cmd                  (s_cmd),
        .s_from_id              (s_from_id),
        .s_msg_term             (s_msg_term),
        .s_cand_id              (s_cand_id),
        .s_req_last_log_index   (s_req_last_log_index),
        .s_req_last_log_term    (s_req_last_log_term),
        .s_is_ack               (s_is_ack),
        .s_local_last_log_index (s_local_last_log_index),
        .s_local_last_log_term  (s_local_last_log_term),
        .q_full                 (q_full),
        .push                   (push),
        .item                   (push_item)
    );

    rle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    rle_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .q_empty                (q_empty),
        .head                   (head),
        .pop                    (pop),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_send_kind            (m_send_kind),
        .m_vote_granted         (m_vote_granted),
        .m_dest_id              (m_dest_id),
        .m_out_term             (m_out_term),
        .m_out_last_log_index   (m_out_last_log_index),
        .m_out_last_log_term    (m_out_last_log_term),
        .m_role                 (m_role),
        .m_became_follower      (m_became_follower),
        .m_became_candidate     (m_became_candidate),
        .m_became_leader        (m_became_leader),
        .m_reset_election_timer (m_reset_election_timer)
    );

endmodule
